[rtl/core/gap_pkg.sv]
package gap_pkg;

  localparam int GridW = 64;
  localparam int GridH = 64;
  localparam int CoordW = 6;
  localparam int Cells = GridW * GridH;
  localparam int CellW = 12;
  localparam int CountW = CellW + 1;
  localparam int CostFracBits = 10;
  localparam int CostW = 24;
  localparam int StampW = 16;
  localparam int DirW = 4;

  localparam int CostOne = 1 << CostFracBits;
  localparam int CostDiag = (1414 * CostOne + 500) / 1000;
  localparam int OctFactor = (414214 * CostOne + 500000) / 1000000;
  localparam int CostMax = (1 << CostW) - 1;

  localparam int SumW = 2 * CoordW + 1;
  localparam int SqW = 2 * ((SumW + 2 * CostFracBits + 1) / 2);
  localparam int SqIters = SqW / 2;
  localparam int RootW = SqIters;
  localparam int RemW = RootW + 3;
  localparam int SqCntW = $clog2(SqIters + 1);

  localparam logic [2:0] KIND_BLOCK = 3'd0;
  localparam logic [2:0] KIND_FREE = 3'd1;
  localparam logic [2:0] KIND_QUERY = 3'd2;
  localparam logic [2:0] KIND_FIND = 3'd3;
  localparam logic [2:0] KIND_READ = 3'd4;

  localparam logic [1:0] HEUR_MANHATTAN = 2'd0;
  localparam logic [1:0] HEUR_EUCLID = 2'd1;
  localparam logic [1:0] HEUR_OCTILE = 2'd2;
  localparam logic [1:0] HEUR_CHEBYSHEV = 2'd3;

  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_OPEN = 2'd1;
  localparam logic [1:0] MARK_CLOSED = 2'd2;

  typedef struct packed {
    logic [CostW-1:0]  f;
    logic [StampW-1:0] stamp;
    logic [CellW-1:0]  node;
  } heap_entry_t;

  function automatic logic entry_less(heap_entry_t a, heap_entry_t b);
    return (a.f < b.f) || ((a.f == b.f) && (a.stamp < b.stamp));
  endfunction

  function automatic logic signed [CoordW+1:0] step_dx(logic [2:0] d);
    logic signed [CoordW+1:0] r;
    case (d)
      3'd1, 3'd5, 3'd6: r = (CoordW+2)'(1);
      3'd3, 3'd4, 3'd7: r = '1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [CoordW+1:0] step_dy(logic [2:0] d);
    logic signed [CoordW+1:0] r;
    case (d)
      3'd2, 3'd6, 3'd7: r = (CoordW+2)'(1);
      3'd0, 3'd4, 3'd5: r = '1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [CostW-1:0] sat_cost(logic [CostW:0] v);
    return v[CostW] ? CostW'(CostMax) : v[CostW-1:0];
  endfunction

endpackage

[rtl/core/grid_astar_path_search_top.sv]
// Grid path search over a 64 x 64 walkability map held in on-chip memory. After reset the
// block marks every cell walkable and accepts no transaction until done. Each input
// transaction returns exactly one output transaction. A search first clears the visit marks,
// then for each cell taken from the open heap sifts the heap level by level and checks each
// neighbour, with an iterative square root per relaxed neighbour under the euclidean
// heuristic. The search speed is set by the single read-modify-write path through the heap
// and node-state memories.
module grid_astar_path_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cell_x[5:0], cell_y[11:6], goal_x[17:12], goal_y[23:18], diagonal[24],
  // use_astar[25], heuristic[27:26], zero[31:28]
  input  logic [31:0] s_axis_tdata_i,
  // kind[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // found[0], path_length[13:1], step_x[19:14], step_y[25:20], is_walkable[26], zero[31:27]
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_QRY, ST_RRD, ST_RESP, ST_CLR, ST_CHK0, ST_CHK1, ST_CHK2,
    ST_POPCHK, ST_POP, ST_CUR, ST_CURG, ST_NB, ST_NBR, ST_SQRT, ST_REL, ST_RQ,
    ST_UP, ST_UPC, ST_DN, ST_DNC, ST_FIN, ST_PATH, ST_PATH2
  } state_e;

  typedef enum logic [1:0] {RET_POP, RET_CUR, RET_NB} ret_e;

  localparam int CW = gap_pkg::CoordW;
  localparam int NW = gap_pkg::CellW;
  localparam int KW = gap_pkg::CostW;

  logic                   wmap_mem [gap_pkg::Cells];
  logic [1:0]             vm_mem   [gap_pkg::Cells];
  logic [KW-1:0]          gc_mem   [gap_pkg::Cells];
  logic [NW-1:0]          cf_mem   [gap_pkg::Cells];
  gap_pkg::heap_entry_t   hp_mem   [gap_pkg::Cells];
  logic [NW-1:0]          hs_mem   [gap_pkg::Cells];
  logic [NW-1:0]          rt_mem   [gap_pkg::Cells];

  logic wmap_we, wmap_wd, wmap_rd;
  logic [NW-1:0] wmap_wa, wmap_ra;
  logic vm_we;
  logic [1:0] vm_wd, vm_rd;
  logic [NW-1:0] vm_wa, vm_ra;
  logic gc_we;
  logic [KW-1:0] gc_wd, gc_rd;
  logic [NW-1:0] gc_wa, gc_ra;
  logic cf_we;
  logic [NW-1:0] cf_wd, cf_rd, cf_wa, cf_ra;
  logic hp_we;
  gap_pkg::heap_entry_t hp_wd, hp_rda, hp_rdb;
  logic [NW-1:0] hp_wa, hp_raa, hp_rab;
  logic hs_we;
  logic [NW-1:0] hs_wd, hs_rd, hs_wa, hs_ra;
  logic rt_we;
  logic [NW-1:0] rt_wd, rt_rd, rt_wa, rt_ra;

  always_ff @(posedge clk_i) begin
    wmap_rd <= wmap_mem[wmap_ra];
    if (wmap_we) wmap_mem[wmap_wa] <= wmap_wd;
  end
  always_ff @(posedge clk_i) begin
    vm_rd <= vm_mem[vm_ra];
    if (vm_we) vm_mem[vm_wa] <= vm_wd;
  end
  always_ff @(posedge clk_i) begin
    gc_rd <= gc_mem[gc_ra];
    if (gc_we) gc_mem[gc_wa] <= gc_wd;
  end
  always_ff @(posedge clk_i) begin
    cf_rd <= cf_mem[cf_ra];
    if (cf_we) cf_mem[cf_wa] <= cf_wd;
  end
  always_ff @(posedge clk_i) begin
    hp_rda <= hp_mem[hp_raa];
    hp_rdb <= hp_mem[hp_rab];
    if (hp_we) hp_mem[hp_wa] <= hp_wd;
  end
  always_ff @(posedge clk_i) begin
    hs_rd <= hs_mem[hs_ra];
    if (hs_we) hs_mem[hs_wa] <= hs_wd;
  end
  always_ff @(posedge clk_i) begin
    rt_rd <= rt_mem[rt_ra];
    if (rt_we) rt_mem[rt_wa] <= rt_wd;
  end

  state_e state_q, state_d;
  ret_e ret_q, ret_d;
  logic [NW-1:0] idx_q, idx_d;
  logic [CW-1:0] sx_q, sx_d, sy_q, sy_d, gx_q, gx_d, gy_q, gy_d;
  logic diag_q, diag_d, astar_q, astar_d, sfree_q, sfree_d;
  logic [1:0] sel_q, sel_d, mark_q, mark_d;
  logic [gap_pkg::CountW-1:0] len_q, len_d, ptr_q, ptr_d, count_q, count_d, pn_q, pn_d;
  logic [gap_pkg::StampW-1:0] stamp_q, stamp_d;
  logic [NW-1:0] pos_q, pos_d, cur_q, cur_d, nb_q, nb_d, pidx_q, pidx_d;
  gap_pkg::heap_entry_t ent_q, ent_d;
  logic [KW-1:0] gcur_q, gcur_d, ng_q, ng_d, h_q, h_d;
  logic [gap_pkg::DirW-1:0] dir_q, dir_d;
  logic [gap_pkg::SqW-1:0] sqv_q, sqv_d;
  logic [gap_pkg::RemW-1:0] rem_q, rem_d;
  logic [gap_pkg::RootW-1:0] root_q, root_d;
  logic [gap_pkg::SqCntW-1:0] sqc_q, sqc_d;
  logic res_walk_q, res_walk_d, res_last_q, res_last_d;
  logic [CW-1:0] res_x_q, res_x_d, res_y_q, res_y_d;
  logic mvalid_q, mvalid_d, mlast_q, mlast_d;
  logic [31:0] mdata_q, mdata_d;

  logic [NW-1:0] start_n, goal_n, in_cell, par_n;
  logic signed [CW+1:0] nx_s, ny_s;
  logic nb_in;
  logic [CW-1:0] ax, ay, lo, hi;
  logic [KW:0] ng_sum, f_sum, oct_sum;
  logic [KW-1:0] ng_c, h_c;
  logic [gap_pkg::SumW-1:0] sq_s;
  logic [gap_pkg::CountW-1:0] lch, rch;
  logic [gap_pkg::RemW-1:0] rem_sh, trial;
  logic [gap_pkg::RootW-1:0] root_n;
  gap_pkg::heap_entry_t best;
  logic [NW-1:0] best_pos;

  assign start_n = {sy_q, sx_q};
  assign goal_n = {gy_q, gx_q};
  assign in_cell = {s_axis_tdata_i[11:6], s_axis_tdata_i[5:0]};
  assign par_n = (pos_q - NW'(1)) >> 1;
  assign lch = {pos_q, 1'b1};
  assign rch = lch + gap_pkg::CountW'(1);

  assign nx_s = $signed({2'b00, cur_q[CW-1:0]}) + gap_pkg::step_dx(dir_q[2:0]);
  assign ny_s = $signed({2'b00, cur_q[NW-1:CW]}) + gap_pkg::step_dy(dir_q[2:0]);
  assign nb_in = !nx_s[CW+1] && (nx_s[CW:0] < (CW+1)'(gap_pkg::GridW)) &&
                 !ny_s[CW+1] && (ny_s[CW:0] < (CW+1)'(gap_pkg::GridH));

  assign ax = (nx_s[CW-1:0] >= gx_q) ? nx_s[CW-1:0] - gx_q : gx_q - nx_s[CW-1:0];
  assign ay = (ny_s[CW-1:0] >= gy_q) ? ny_s[CW-1:0] - gy_q : gy_q - ny_s[CW-1:0];
  assign lo = (ax < ay) ? ax : ay;
  assign hi = (ax < ay) ? ay : ax;
  assign oct_sum = (KW+1)'(gap_pkg::OctFactor) * (KW+1)'(lo) +
                   ((KW+1)'(hi) << gap_pkg::CostFracBits);
  assign sq_s = gap_pkg::SumW'(ax) * gap_pkg::SumW'(ax) +
                gap_pkg::SumW'(ay) * gap_pkg::SumW'(ay);

  always_comb begin
    case (sel_q)
      gap_pkg::HEUR_MANHATTAN:
        h_c = diag_q ? gap_pkg::sat_cost(oct_sum)
                     : gap_pkg::sat_cost(((KW+1)'(ax) + (KW+1)'(ay))
                                         << gap_pkg::CostFracBits);
      gap_pkg::HEUR_OCTILE: h_c = gap_pkg::sat_cost(oct_sum);
      default: h_c = gap_pkg::sat_cost((KW+1)'(hi) << gap_pkg::CostFracBits);
    endcase
  end

  assign ng_sum = {1'b0, gcur_q} + ((dir_q >= gap_pkg::DirW'(4)) ?
                  (KW+1)'(gap_pkg::CostDiag) : (KW+1)'(gap_pkg::CostOne));
  assign ng_c = gap_pkg::sat_cost(ng_sum);
  assign f_sum = {1'b0, ng_q} + {1'b0, h_q};

  assign rem_sh = {rem_q[gap_pkg::RemW-3:0], sqv_q[gap_pkg::SqW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign root_n = {root_q[gap_pkg::RootW-2:0], (rem_sh >= trial)};

  always_comb begin
    best = ent_q;
    best_pos = pos_q;
    if (gap_pkg::entry_less(hp_rda, best)) begin
      best = hp_rda;
      best_pos = lch[NW-1:0];
    end
    if ((rch < count_q) && gap_pkg::entry_less(hp_rdb, best)) begin
      best = hp_rdb;
      best_pos = rch[NW-1:0];
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o = mdata_q;
  assign m_axis_tlast_o = mlast_q;

  always_comb begin
    state_d = state_q; ret_d = ret_q; idx_d = idx_q;
    sx_d = sx_q; sy_d = sy_q; gx_d = gx_q; gy_d = gy_q;
    diag_d = diag_q; astar_d = astar_q; sel_d = sel_q; sfree_d = sfree_q; mark_d = mark_q;
    len_d = len_q; ptr_d = ptr_q; count_d = count_q; pn_d = pn_q; stamp_d = stamp_q;
    pos_d = pos_q; cur_d = cur_q; nb_d = nb_q; pidx_d = pidx_q; ent_d = ent_q;
    gcur_d = gcur_q; ng_d = ng_q; h_d = h_q; dir_d = dir_q;
    sqv_d = sqv_q; rem_d = rem_q; root_d = root_q; sqc_d = sqc_q;
    res_walk_d = res_walk_q; res_last_d = res_last_q; res_x_d = res_x_q; res_y_d = res_y_q;
    mvalid_d = mvalid_q && !m_axis_tready_i; mlast_d = mlast_q; mdata_d = mdata_q;

    wmap_we = 1'b0; wmap_wa = idx_q; wmap_wd = 1'b1; wmap_ra = in_cell;
    vm_we = 1'b0; vm_wa = nb_q; vm_wd = gap_pkg::MARK_OPEN; vm_ra = nb_q;
    gc_we = 1'b0; gc_wa = nb_q; gc_wd = ng_q; gc_ra = nb_q;
    cf_we = 1'b0; cf_wa = nb_q; cf_wd = cur_q; cf_ra = pidx_q;
    hp_we = 1'b0; hp_wa = pos_q; hp_wd = ent_q; hp_raa = lch[NW-1:0]; hp_rab = rch[NW-1:0];
    hs_we = 1'b0; hs_wa = ent_q.node; hs_wd = pos_q; hs_ra = nb_q;
    rt_we = 1'b0; rt_wa = pn_q[NW-1:0]; rt_wd = pidx_q;
    rt_ra = NW'(len_q - ptr_q - gap_pkg::CountW'(1));

    case (state_q)
      ST_INIT: begin
        wmap_we = 1'b1;
        idx_d = idx_q + NW'(1);
        if (idx_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          sx_d = s_axis_tdata_i[5:0];
          sy_d = s_axis_tdata_i[11:6];
          gx_d = s_axis_tdata_i[17:12];
          gy_d = s_axis_tdata_i[23:18];
          diag_d = s_axis_tdata_i[24];
          astar_d = s_axis_tdata_i[25];
          sel_d = s_axis_tdata_i[27:26];
          res_walk_d = 1'b0; res_last_d = 1'b0; res_x_d = '0; res_y_d = '0;
          case (s_axis_tuser_i)
            gap_pkg::KIND_BLOCK, gap_pkg::KIND_FREE: begin
              wmap_we = 1'b1;
              wmap_wa = in_cell;
              wmap_wd = s_axis_tuser_i[0];
              state_d = ST_RESP;
            end
            gap_pkg::KIND_QUERY: state_d = ST_QRY;
            gap_pkg::KIND_FIND: begin
              len_d = '0;
              ptr_d = '0;
              idx_d = '0;
              state_d = ST_CLR;
            end
            gap_pkg::KIND_READ: begin
              if (ptr_q < len_q) begin
                state_d = ST_RRD;
              end else begin
                res_last_d = 1'b1;
                state_d = ST_RESP;
              end
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_QRY: begin
        res_walk_d = wmap_rd;
        state_d = ST_RESP;
      end
      ST_RRD: begin
        res_x_d = rt_rd[CW-1:0];
        res_y_d = rt_rd[NW-1:CW];
        ptr_d = ptr_q + gap_pkg::CountW'(1);
        res_last_d = (ptr_q + gap_pkg::CountW'(1)) == len_q;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mvalid_d = 1'b1;
          mlast_d = res_last_q;
          mdata_d = {5'b0, res_walk_q, res_y_q, res_x_q, len_q, (len_q != '0)};
          state_d = ST_IDLE;
        end
      end
      ST_CLR: begin
        vm_we = 1'b1;
        vm_wa = idx_q;
        vm_wd = gap_pkg::MARK_NONE;
        idx_d = idx_q + NW'(1);
        if (idx_q == '1) begin
          count_d = '0;
          stamp_d = '0;
          state_d = ST_CHK0;
        end
      end
      ST_CHK0: begin
        wmap_ra = start_n;
        state_d = ST_CHK1;
      end
      ST_CHK1: begin
        sfree_d = wmap_rd;
        wmap_ra = goal_n;
        state_d = ST_CHK2;
      end
      ST_CHK2: begin
        if (!sfree_q || !wmap_rd) begin
          state_d = ST_RESP;
        end else begin
          vm_we = 1'b1;
          vm_wa = start_n;
          gc_we = 1'b1;
          gc_wa = start_n;
          gc_wd = '0;
          ent_d = '{f: '0, stamp: stamp_q, node: start_n};
          stamp_d = stamp_q + gap_pkg::StampW'(1);
          pos_d = '0;
          count_d = gap_pkg::CountW'(1);
          ret_d = RET_POP;
          state_d = ST_UP;
        end
      end
      ST_POPCHK: begin
        hp_raa = '0;
        hp_rab = NW'(count_q - gap_pkg::CountW'(1));
        state_d = (count_q == '0) ? ST_RESP : ST_POP;
      end
      ST_POP: begin
        cur_d = hp_rda.node;
        vm_we = 1'b1;
        vm_wa = hp_rda.node;
        vm_wd = gap_pkg::MARK_CLOSED;
        count_d = count_q - gap_pkg::CountW'(1);
        if (count_q > gap_pkg::CountW'(1)) begin
          ent_d = hp_rdb;
          pos_d = '0;
          ret_d = RET_CUR;
          state_d = ST_DN;
        end else begin
          state_d = ST_CUR;
        end
      end
      ST_CUR: begin
        gc_ra = cur_q;
        dir_d = '0;
        if (cur_q == goal_n) begin
          pidx_d = goal_n;
          pn_d = '0;
          state_d = ST_PATH;
        end else begin
          state_d = ST_CURG;
        end
      end
      ST_CURG: begin
        gcur_d = gc_rd;
        state_d = ST_NB;
      end
      ST_NB: begin
        wmap_ra = {ny_s[CW-1:0], nx_s[CW-1:0]};
        vm_ra = {ny_s[CW-1:0], nx_s[CW-1:0]};
        gc_ra = {ny_s[CW-1:0], nx_s[CW-1:0]};
        nb_d = {ny_s[CW-1:0], nx_s[CW-1:0]};
        if (dir_q == (diag_q ? gap_pkg::DirW'(8) : gap_pkg::DirW'(4))) begin
          state_d = ST_POPCHK;
        end else if (!nb_in) begin
          dir_d = dir_q + gap_pkg::DirW'(1);
        end else begin
          state_d = ST_NBR;
        end
      end
      ST_NBR: begin
        if (!wmap_rd || (vm_rd == gap_pkg::MARK_CLOSED) ||
            !((vm_rd == gap_pkg::MARK_NONE) || (ng_c < gc_rd))) begin
          dir_d = dir_q + gap_pkg::DirW'(1);
          state_d = ST_NB;
        end else begin
          ng_d = ng_c;
          mark_d = vm_rd;
          if (!astar_q) begin
            h_d = '0;
            state_d = ST_REL;
          end else if (sel_q == gap_pkg::HEUR_EUCLID) begin
            sqv_d = gap_pkg::SqW'({sq_s, {(2 * gap_pkg::CostFracBits){1'b0}}});
            rem_d = '0;
            root_d = '0;
            sqc_d = '0;
            state_d = ST_SQRT;
          end else begin
            h_d = h_c;
            state_d = ST_REL;
          end
        end
      end
      ST_SQRT: begin
        rem_d = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
        root_d = root_n;
        sqv_d = sqv_q << 2;
        sqc_d = sqc_q + gap_pkg::SqCntW'(1);
        if (sqc_q == gap_pkg::SqCntW'(gap_pkg::SqIters - 1)) begin
          h_d = KW'(root_n);
          state_d = ST_REL;
        end
      end
      ST_REL: begin
        gc_we = 1'b1;
        cf_we = 1'b1;
        vm_we = 1'b1;
        ent_d = '{f: gap_pkg::sat_cost(f_sum), stamp: stamp_q, node: nb_q};
        stamp_d = stamp_q + gap_pkg::StampW'(1);
        ret_d = RET_NB;
        if (mark_q == gap_pkg::MARK_OPEN) begin
          state_d = ST_RQ;
        end else begin
          pos_d = NW'(count_q);
          count_d = count_q + gap_pkg::CountW'(1);
          state_d = ST_UP;
        end
      end
      ST_RQ: begin
        pos_d = hs_rd;
        state_d = ST_UP;
      end
      ST_UP: begin
        hp_raa = par_n;
        state_d = (pos_q == '0) ? ST_DN : ST_UPC;
      end
      ST_UPC: begin
        if (gap_pkg::entry_less(ent_q, hp_rda)) begin
          hp_we = 1'b1;
          hp_wd = hp_rda;
          hs_we = 1'b1;
          hs_wa = hp_rda.node;
          pos_d = par_n;
          state_d = ST_UP;
        end else begin
          state_d = ST_DN;
        end
      end
      ST_DN: begin
        state_d = (lch >= count_q) ? ST_FIN : ST_DNC;
      end
      ST_DNC: begin
        if (best_pos == pos_q) begin
          state_d = ST_FIN;
        end else begin
          hp_we = 1'b1;
          hp_wd = best;
          hs_we = 1'b1;
          hs_wa = best.node;
          pos_d = best_pos;
          state_d = ST_DN;
        end
      end
      ST_FIN: begin
        hp_we = 1'b1;
        hs_we = 1'b1;
        case (ret_q)
          RET_POP: state_d = ST_POPCHK;
          RET_CUR: state_d = ST_CUR;
          default: begin
            dir_d = dir_q + gap_pkg::DirW'(1);
            state_d = ST_NB;
          end
        endcase
      end
      ST_PATH: begin
        rt_we = 1'b1;
        pn_d = pn_q + gap_pkg::CountW'(1);
        if (pidx_q == start_n) begin
          len_d = pn_q + gap_pkg::CountW'(1);
          ptr_d = '0;
          state_d = ST_RESP;
        end else begin
          state_d = ST_PATH2;
        end
      end
      ST_PATH2: begin
        pidx_d = cf_rd;
        state_d = ST_PATH;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT; ret_q <= RET_POP; idx_q <= '0;
      sx_q <= '0; sy_q <= '0; gx_q <= '0; gy_q <= '0;
      diag_q <= 1'b0; astar_q <= 1'b0; sel_q <= '0; sfree_q <= 1'b0; mark_q <= '0;
      len_q <= '0; ptr_q <= '0; count_q <= '0; pn_q <= '0; stamp_q <= '0;
      pos_q <= '0; cur_q <= '0; nb_q <= '0; pidx_q <= '0; ent_q <= '0;
      gcur_q <= '0; ng_q <= '0; h_q <= '0; dir_q <= '0;
      sqv_q <= '0; rem_q <= '0; root_q <= '0; sqc_q <= '0;
      res_walk_q <= 1'b0; res_last_q <= 1'b0; res_x_q <= '0; res_y_q <= '0;
      mvalid_q <= 1'b0; mlast_q <= 1'b0; mdata_q <= '0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; idx_q <= idx_d;
      sx_q <= sx_d; sy_q <= sy_d; gx_q <= gx_d; gy_q <= gy_d;
      diag_q <= diag_d; astar_q <= astar_d; sel_q <= sel_d; sfree_q <= sfree_d;
      mark_q <= mark_d;
      len_q <= len_d; ptr_q <= ptr_d; count_q <= count_d; pn_q <= pn_d; stamp_q <= stamp_d;
      pos_q <= pos_d; cur_q <= cur_d; nb_q <= nb_d; pidx_q <= pidx_d; ent_q <= ent_d;
      gcur_q <= gcur_d; ng_q <= ng_d; h_q <= h_d; dir_q <= dir_d;
      sqv_q <= sqv_d; rem_q <= rem_d; root_q <= root_d; sqc_q <= sqc_d;
      res_walk_q <= res_walk_d; res_last_q <= res_last_d; res_x_q <= res_x_d;
      res_y_q <= res_y_d;
      mvalid_q <= mvalid_d; mlast_q <= mlast_d; mdata_q <= mdata_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_heap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= gap_pkg::CountW'(gap_pkg::Cells))
    else $error("Open heap holds more entries than there are cells.");

  a_read_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= len_q)
    else $error("Path read pointer ran past the stored path.");

  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[0] == (m_axis_tdata_o[13:1] != '0)))
    else $error("Found flag disagrees with the path length.");
`endif

endmodule
